// ===== src/change_detector_rate_mode_assert.svh =====
// ----------------------------------------------------------------------------
// change detector assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CHANGE_DETECTOR_RATE_MODE_ASSERT_SVH
`define CHANGE_DETECTOR_RATE_MODE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CDRM_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("cdrm assertion failed");
// next-cycle implication
`define CDRM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("cdrm assertion failed");
`else
`define CDRM_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define CDRM_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== src/cdrm_pkg.sv =====
// ----------------------------------------------------------------------------
// cdrm_pkg
// shared types and constants of the change detector
// ----------------------------------------------------------------------------
package cdrm_pkg;

	localparam int CH_W       = 4;
	localparam int CH_NUM     = 2 ** CH_W;
	localparam int SMP_W      = 32;
	localparam int PCT_W      = 7;
	localparam int MINB_W     = 16;
	localparam int FCL_W      = 4;
	localparam int STC_W      = 8;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PCT_W-1:0]  RST_PCT  = 7'd10;
	localparam logic [MINB_W-1:0] RST_MINB = 16'd128;
	localparam logic [FCL_W-1:0]  RST_FCL  = 4'd2;
	localparam logic [STC_W-1:0]  RST_STC  = 8'd3;

	localparam logic [STC_W-1:0]  STC_MAX  = 8'd255;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_EVAL   = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BAND_PCT          = 2'd0,
		REG_MIN_BAND          = 2'd1,
		REG_MIN_FAST_CYCLES   = 2'd2,
		REG_STABLE_CHECKS     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		TA_NONE    = 2'd0,
		TA_CLAMP   = 2'd1,
		TA_RESTART = 2'd2
	} timer_act_t;

	typedef enum logic {
		MODE_SLOW = 1'b0,
		MODE_FAST = 1'b1
	} mode_t;

	typedef struct packed {
		logic [PCT_W-1:0]  band_pct;
		logic [MINB_W-1:0] min_band;
		logic [FCL_W-1:0]  min_fast_cycles;
		logic [STC_W-1:0]  stable_checks;
	} cfg_t;

	typedef struct packed {
		logic       fast;
		timer_act_t action;
	} mode_res_t;

endpackage

// ===== src/cdrm_prev_store.sv =====
// ----------------------------------------------------------------------------
// cdrm_prev_store
// per-channel previous value memory with valid bits and write forwarding
// ----------------------------------------------------------------------------
`include "change_detector_rate_mode_assert.svh"

module cdrm_prev_store #(
	parameter int DEPTH = 16,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [IDX_W-1:0]            rd_idx,
	input  logic                        wr_en,
	input  logic [IDX_W-1:0]            wr_idx,
	input  logic [cdrm_pkg::SMP_W-1:0]  wr_data,
	output logic [cdrm_pkg::SMP_W-1:0]  rd_data
);

	logic [cdrm_pkg::SMP_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]           vld_q;
	logic [cdrm_pkg::SMP_W-1:0] rd_data_s1;
	logic                       rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	// forward the write of the same edge, otherwise registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else if (rd_en) begin
			if (wr_en && (wr_idx == rd_idx)) begin
				rd_vld_s1 <= 1'b1;
			end else begin
				rd_vld_s1 <= vld_q[rd_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_idx == rd_idx)) begin
				rd_data_s1 <= wr_data;
			end else begin
				rd_data_s1 <= mem[rd_idx];
			end
		end
	end

	// unwritten entries read as zero
	assign rd_data = rd_vld_s1 ? rd_data_s1 : '0;

	`CDRM_ASSERT_NEXT(a_wr_sets_valid, clk, arst_n, wr_en, vld_q[$past(wr_idx)])

endmodule

// ===== src/cdrm_band.sv =====
// ----------------------------------------------------------------------------
// cdrm_band
// deadband test of one sample against its channel's previous value
// ----------------------------------------------------------------------------
module cdrm_band (
	input  logic signed [cdrm_pkg::SMP_W-1:0] cur,
	input  logic signed [cdrm_pkg::SMP_W-1:0] prev,
	input  logic                              fast,
	input  cdrm_pkg::cfg_t                    cfg,
	output logic                              hit
);

	localparam int D_W   = cdrm_pkg::SMP_W + 1;
	localparam int PE_W  = cdrm_pkg::PCT_W + 3;
	localparam int RHS_W = cdrm_pkg::SMP_W + PE_W;
	localparam int LHS_W = D_W + PE_W;

	logic signed [D_W-1:0]           diff;
	logic [D_W-1:0]                  absd;
	logic [cdrm_pkg::SMP_W-1:0]      mag;
	logic [PE_W-1:0]                 pct_x;
	logic [PE_W-1:0]                 pct_eff;
	logic [LHS_W-1:0]                dx;
	logic [LHS_W-1:0]                lhs;
	logic [RHS_W-1:0]                rhs;
	logic                            over_pct;
	logic                            over_min;

	// |d| > floor(P/D) is the same as |d|*D > P, so no divider is needed
	always_comb begin
		diff    = D_W'(cur) - D_W'(prev);
		absd    = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
		mag     = prev[cdrm_pkg::SMP_W-1] ? cdrm_pkg::SMP_W'(-prev)
			: cdrm_pkg::SMP_W'(prev);
		pct_x   = PE_W'(cfg.band_pct);
		pct_eff = fast ? PE_W'((pct_x << 3) - pct_x) : pct_x;
		rhs     = RHS_W'(mag) * RHS_W'(pct_eff);
		dx      = LHS_W'(absd);
		// times 1000 in fast mode, times 100 in slow mode
		lhs     = fast ? ((dx << 10) - (dx << 4) - (dx << 3))
			: ((dx << 6) + (dx << 5) + (dx << 2));
		over_pct = lhs > LHS_W'(rhs);
		over_min = absd > D_W'(cfg.min_band);
		hit      = over_pct && over_min;
	end

endmodule

// ===== src/cdrm_mode.sv =====
// ----------------------------------------------------------------------------
// cdrm_mode
// slow/fast refresh mode machine run by evaluate items
// ----------------------------------------------------------------------------
`include "change_detector_rate_mode_assert.svh"

module cdrm_mode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 eval,
	input  logic                 any,
	input  logic                 cycle_sent,
	input  cdrm_pkg::cfg_t       cfg,
	output logic                 fast,
	output cdrm_pkg::mode_res_t  res
);

	cdrm_pkg::mode_t                mode_q, mode_n;
	logic [cdrm_pkg::STC_W-1:0]     stable_q, stable_n, stable_inc;
	logic [cdrm_pkg::FCL_W-1:0]     fcl_q, fcl_n, fcl_dec;
	logic                           leave;
	logic                           clamp;
	logic                           restart;

	always_comb begin
		stable_inc = (stable_q == cdrm_pkg::STC_MAX) ? stable_q : stable_q + 1'b1;
		fcl_dec    = (cycle_sent && (fcl_q != '0)) ? fcl_q - 1'b1 : fcl_q;
		leave      = (fcl_dec == '0) && (stable_inc >= cfg.stable_checks);
		mode_n     = mode_q;
		stable_n   = stable_q;
		fcl_n      = fcl_q;
		if (eval) begin
			if (any) begin
				mode_n   = cdrm_pkg::MODE_FAST;
				stable_n = '0;
				fcl_n    = cfg.min_fast_cycles;
			end else begin
				case (mode_q)
					cdrm_pkg::MODE_FAST: begin
						fcl_n = fcl_dec;
						if (leave) begin
							mode_n   = cdrm_pkg::MODE_SLOW;
							stable_n = '0;
						end else begin
							stable_n = stable_inc;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		clamp   = any && (mode_q == cdrm_pkg::MODE_SLOW);
		restart = !any && (mode_q == cdrm_pkg::MODE_FAST) && leave;
		fast    = (mode_q == cdrm_pkg::MODE_FAST);
		res.fast = (mode_n == cdrm_pkg::MODE_FAST);
		if (clamp) begin
			res.action = cdrm_pkg::TA_CLAMP;
		end else if (restart) begin
			res.action = cdrm_pkg::TA_RESTART;
		end else begin
			res.action = cdrm_pkg::TA_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= cdrm_pkg::MODE_SLOW;
			stable_q <= '0;
			fcl_q    <= '0;
		end else begin
			mode_q   <= mode_n;
			stable_q <= stable_n;
			fcl_q    <= fcl_n;
		end
	end

	`CDRM_ASSERT_NEXT(a_clamp_enters_fast, clk, arst_n, eval && clamp, (mode_q == cdrm_pkg::MODE_FAST) && (fcl_q == $past(cfg.min_fast_cycles)))
	`CDRM_ASSERT_NEXT(a_restart_to_slow, clk, arst_n, eval && restart, (mode_q == cdrm_pkg::MODE_SLOW) && (stable_q == '0))
	`CDRM_ASSERT_NEXT(a_mode_holds_idle, clk, arst_n, !eval, mode_q == $past(mode_q))

endmodule

// ===== src/change_detector_rate_mode.sv =====
// ----------------------------------------------------------------------------
// change_detector_rate_mode
// percentage deadband change detector with slow/fast refresh mode machine
// ----------------------------------------------------------------------------
// usage
//   s_* stream carries items: tuser is the op (0 sample, 1 evaluate), tlast is
//   last_in_group, tdata packs channel, sample_value, group and cycle_sent
//   m_* stream returns one result per item: out_of_band, fast_mode and
//   timer_action packed in tdata
//   cfg_wen/cfg_idx/cfg_wdata write the four registers, only while idle
// path: an accepted item enters the input register, and its result moves
//   into the result register, which raises m_tvalid, once that is free
// throughput: one item per cycle while m_tready is high; the band test, group
//   flags and mode machine all settle as logic between the two registers
// stall: a waiting result holds in the result register while one more item
//   sits in the input register; s_tready drops only when both are full
// reset: previous values read as zero, slow mode, all group flags and
//   counters clear, registers return to 10, 128, 2 and 3
// ----------------------------------------------------------------------------
module change_detector_rate_mode #(
	parameter int CHANNELS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// channel[3:0], sample_value[35:4], group[36], cycle_sent[37], zero[39:38]
	input  logic [cdrm_pkg::IN_DATA_W-1:0]      s_tdata,
	// op[0]
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_of_band[0], fast_mode[1], timer_action[3:2], zero[7:4]
	output logic [cdrm_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_wen,
	input  logic [cdrm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [cdrm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// configuration registers
	cdrm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_pct          <= cdrm_pkg::RST_PCT;
			cfg_q.min_band          <= cdrm_pkg::RST_MINB;
			cfg_q.min_fast_cycles   <= cdrm_pkg::RST_FCL;
			cfg_q.stable_checks     <= cdrm_pkg::RST_STC;
		end else if (cfg_wen) begin
			case (cdrm_pkg::reg_idx_t'(cfg_idx))
				cdrm_pkg::REG_BAND_PCT:
					cfg_q.band_pct <= cfg_wdata[cdrm_pkg::PCT_W-1:0];
				cdrm_pkg::REG_MIN_BAND:
					cfg_q.min_band <= cfg_wdata[cdrm_pkg::MINB_W-1:0];
				cdrm_pkg::REG_MIN_FAST_CYCLES:
					cfg_q.min_fast_cycles <= cfg_wdata[cdrm_pkg::FCL_W-1:0];
				cdrm_pkg::REG_STABLE_CHECKS:
					cfg_q.stable_checks <= cfg_wdata[cdrm_pkg::STC_W-1:0];
				default: ;
			endcase
		end
	end

	// channel number wrapped onto the store depth, one constant per code
	logic [IW-1:0] wrap_tab [cdrm_pkg::CH_NUM];

	for (genvar g = 0; g < cdrm_pkg::CH_NUM; g++) begin : g_wrap
		assign wrap_tab[g] = IW'(g % CHANNELS);
	end

	// handshake between input register and result register
	logic v_s1;
	logic ov_q;
	logic adv;
	logic acc;

	assign adv      = v_s1 && (!ov_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// input register payload
	cdrm_pkg::op_t                  op_s1;
	logic [IW-1:0]                  idx_s1;
	logic [cdrm_pkg::SMP_W-1:0]     smp_s1;
	logic                           grp_s1;
	logic                           last_s1;
	logic                           sent_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1   <= cdrm_pkg::op_t'(s_tuser);
			idx_s1  <= wrap_tab[s_tdata[3:0]];
			smp_s1  <= s_tdata[35:4];
			grp_s1  <= s_tdata[36];
			last_s1 <= s_tlast;
			sent_s1 <= s_tdata[37];
		end
	end

	logic is_sample;
	logic is_eval;

	assign is_sample = (op_s1 == cdrm_pkg::OP_SAMPLE);
	assign is_eval   = (op_s1 == cdrm_pkg::OP_EVAL);

	// previous value store, read as the item enters, written as it leaves
	logic [cdrm_pkg::SMP_W-1:0] prev;

	cdrm_prev_store #(
		.DEPTH (CHANNELS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_idx  (wrap_tab[s_tdata[3:0]]),
		.wr_en   (adv && is_sample),
		.wr_idx  (idx_s1),
		.wr_data (smp_s1),
		.rd_data (prev)
	);

	// band test uses the mode left by earlier evaluates
	logic mode_fast;
	logic hit;

	cdrm_band u_band (
		.cur  (smp_s1),
		.prev (prev),
		.fast (mode_fast),
		.cfg  (cfg_q),
		.hit  (hit)
	);

	// group exceed flags: running OR, latched on the group's last sample
	logic [1:0] run_q;
	logic [1:0] lat_q;
	logic       run_or;
	logic       any;

	assign run_or = run_q[grp_s1] | hit;
	assign any    = |lat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			lat_q <= '0;
		end else if (adv && is_sample) begin
			if (last_s1) begin
				lat_q[grp_s1] <= run_or;
				run_q[grp_s1] <= 1'b0;
			end else begin
				run_q[grp_s1] <= run_or;
			end
		end
	end

	// mode machine steps on evaluate items only
	cdrm_pkg::mode_res_t mres;

	cdrm_mode u_mode (
		.clk        (clk),
		.arst_n     (arst_n),
		.eval       (adv && is_eval),
		.any        (any),
		.cycle_sent (sent_s1),
		.cfg        (cfg_q),
		.fast       (mode_fast),
		.res        (mres)
	);

	// result register
	logic                 oob_q;
	logic                 fast_q;
	cdrm_pkg::timer_act_t act_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (is_eval) begin
				oob_q  <= any;
				fast_q <= mres.fast;
				act_q  <= mres.action;
			end else begin
				oob_q  <= hit;
				fast_q <= mode_fast;
				act_q  <= cdrm_pkg::TA_NONE;
			end
		end
	end

	assign m_tdata = {4'b0000, act_q, fast_q, oob_q};

endmodule
